// File: sv/tdg_pkg.sv
// ----------------------------------------------------------------------------
// tdg_pkg
// Shared widths, tile sizes, register indexes and stage payload types of the
// gemm tile descriptor generator.
// ----------------------------------------------------------------------------
package tdg_pkg;

   // tile sizes, powers of two between 4 and 4096
   localparam int TILE_M = 256;
   localparam int TILE_N = 256;
   localparam int TILE_K = 256;

   localparam int IDX_W  = 12;
   localparam int TOT_W  = 20;
   localparam int LD_W   = 20;
   localparam int MODE_W = 2;
   localparam int LEN_W  = 9;
   localparam int OFS_W  = 40;
   localparam int CNT_W  = 36;

   localparam int LEN_MAX = 2**LEN_W - 1;
   localparam logic [63:0] COUNT_MAX = (64'd1 << CNT_W) - 64'd1;

   // grid count widths: largest quotient plus one short tile
   localparam int CNT_M_W = $clog2((2**TOT_W - 1) / TILE_M + 2);
   localparam int CNT_N_W = $clog2((2**TOT_W - 1) / TILE_N + 2);
   localparam int CNT_K_W = $clog2((2**TOT_W - 1) / TILE_K + 2);
   localparam int CNT_MAXW = (CNT_M_W > CNT_N_W)
                             ? ((CNT_M_W > CNT_K_W) ? CNT_M_W : CNT_K_W)
                             : ((CNT_N_W > CNT_K_W) ? CNT_N_W : CNT_K_W);
   localparam int DIM_W = ((IDX_W > CNT_MAXW) ? IDX_W : CNT_MAXW) + 1;
   localparam int MN_W  = CNT_M_W + CNT_N_W;
   localparam int CNTP_W = MN_W + CNT_K_W;

   // element origin of a tile index along each dimension
   localparam int SCL_M_W = IDX_W + $clog2(TILE_M);
   localparam int SCL_N_W = IDX_W + $clog2(TILE_N);
   localparam int SCL_K_W = IDX_W + $clog2(TILE_K);
   localparam int SCL_W = (SCL_M_W > SCL_N_W)
                          ? ((SCL_M_W > SCL_K_W) ? SCL_M_W : SCL_K_W)
                          : ((SCL_N_W > SCL_K_W) ? SCL_N_W : SCL_K_W);
   localparam int PRD_W = SCL_W + LD_W;

   // op_mode bits
   localparam int MODE_A_TRANS = 0;
   localparam int MODE_B_TRANS = 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OP_MODE = 3'd0,
      CSR_M_TOTAL = 3'd1,
      CSR_N_TOTAL = 3'd2,
      CSR_K_TOTAL = 3'd3,
      CSR_LD_A    = 3'd4,
      CSR_LD_B    = 3'd5,
      CSR_LD_C    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic en;
      logic vld_in;
   } stg_ctrl_type;

   typedef struct packed {
      logic               in_range;
      logic [LEN_W-1:0]   m_len;
      logic [LEN_W-1:0]   n_len;
      logic [LEN_W-1:0]   k_len;
      logic               first_k;
      logic               last_k;
      logic [CNT_M_W-1:0] gm;
      logic [CNT_N_W-1:0] gn;
      logic [CNT_K_W-1:0] gk;
      logic [SCL_W-1:0]   a_x;
      logic [SCL_W-1:0]   a_y;
      logic [SCL_W-1:0]   b_x;
      logic [SCL_W-1:0]   b_y;
      logic [SCL_W-1:0]   c_x;
      logic [SCL_W-1:0]   c_y;
   } s1_type;

   typedef struct packed {
      logic               in_range;
      logic [LEN_W-1:0]   m_len;
      logic [LEN_W-1:0]   n_len;
      logic [LEN_W-1:0]   k_len;
      logic               first_k;
      logic               last_k;
      logic [MN_W-1:0]    gmn;
      logic [CNT_K_W-1:0] gk;
      logic [PRD_W-1:0]   a_p;
      logic [PRD_W-1:0]   b_p;
      logic [PRD_W-1:0]   c_p;
      logic [SCL_W-1:0]   a_y;
      logic [SCL_W-1:0]   b_y;
      logic [SCL_W-1:0]   c_y;
   } s2_type;

   typedef struct packed {
      logic             in_range;
      logic [LEN_W-1:0] m_len;
      logic [LEN_W-1:0] n_len;
      logic [LEN_W-1:0] k_len;
      logic [OFS_W-1:0] a_offset;
      logic [OFS_W-1:0] b_offset;
      logic [OFS_W-1:0] c_offset;
      logic             first_k;
      logic             last_k;
      logic [CNT_W-1:0] tile_count;
   } s3_type;

   // length of tile idx: the last tile of the grid takes last, others tile, capped at LEN_MAX
   function automatic logic [LEN_W-1:0] dim_len(input logic [DIM_W-1:0] idx,
                                                 input logic [DIM_W-1:0] g,
                                                 input logic [TOT_W-1:0] last,
                                                 input logic [TOT_W-1:0] tile);
      logic [TOT_W-1:0] len;
      len = ((idx + DIM_W'(1)) == g) ? last : tile;
      if (len > TOT_W'(LEN_MAX)) begin
         return LEN_W'(LEN_MAX);
      end
      return LEN_W'(len);
   endfunction

endpackage

// File: sv/gemm_tile_descriptor_generator_top.sv
// ----------------------------------------------------------------------------
// gemm_tile_descriptor_generator_top
// Tile descriptor generator for a blocked matrix multiply.
// ----------------------------------------------------------------------------
// Takes one (m, n, k) tile index per cycle while req_stall is low and
// returns its range flag, lengths, A/B/C element origins, k flags and the
// grid's tile count. The path is three register stages (grid and operand
// select, 20x20 origin multiplies, origin adds and count saturation), and
// one item per cycle is sustained while rsp_stall is low. Each stage moves
// on when the next one is empty or moving, so a stall on the result side
// fills the bubbles first and reaches req_stall only when all three stages
// hold items. Configuration registers are to be written by the user only
// while no item is in flight; the block itself does not enforce this.
module gemm_tile_descriptor_generator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tdg_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [tdg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tdg_pkg::IDX_W-1:0]        req_m_tile,
   input  logic [tdg_pkg::IDX_W-1:0]        req_n_tile,
   input  logic [tdg_pkg::IDX_W-1:0]        req_k_tile,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_in_range,
   output logic [tdg_pkg::LEN_W-1:0]        rsp_m_len,
   output logic [tdg_pkg::LEN_W-1:0]        rsp_n_len,
   output logic [tdg_pkg::LEN_W-1:0]        rsp_k_len,
   output logic [tdg_pkg::OFS_W-1:0]        rsp_a_offset,
   output logic [tdg_pkg::OFS_W-1:0]        rsp_b_offset,
   output logic [tdg_pkg::OFS_W-1:0]        rsp_c_offset,
   output logic                             rsp_first_k,
   output logic                             rsp_last_k,
   output logic [tdg_pkg::CNT_W-1:0]        rsp_tile_count
);

   logic [tdg_pkg::MODE_W-1:0] op_mode_ff;
   logic [tdg_pkg::TOT_W-1:0]  m_total_ff;
   logic [tdg_pkg::TOT_W-1:0]  n_total_ff;
   logic [tdg_pkg::TOT_W-1:0]  k_total_ff;
   logic [tdg_pkg::LD_W-1:0]   ld_a_ff;
   logic [tdg_pkg::LD_W-1:0]   ld_b_ff;
   logic [tdg_pkg::LD_W-1:0]   ld_c_ff;

   logic                  v1;
   logic                  v2;
   logic                  v3;
   logic                  ready1;
   logic                  ready2;
   logic                  ready3;
   tdg_pkg::stg_ctrl_type c1;
   tdg_pkg::stg_ctrl_type c2;
   tdg_pkg::stg_ctrl_type c3;
   tdg_pkg::s1_type       s1;
   tdg_pkg::s2_type       s2;
   tdg_pkg::s3_type       s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= '0;
         m_total_ff <= '0;
         n_total_ff <= '0;
         k_total_ff <= '0;
         ld_a_ff    <= tdg_pkg::LD_W'(1);
         ld_b_ff    <= tdg_pkg::LD_W'(1);
         ld_c_ff    <= tdg_pkg::LD_W'(1);
      end else if (csr_wr_en) begin
         case (tdg_pkg::csr_index_type'(csr_idx))
            tdg_pkg::CSR_OP_MODE: op_mode_ff <= csr_wdata[tdg_pkg::MODE_W-1:0];
            tdg_pkg::CSR_M_TOTAL: m_total_ff <= csr_wdata[tdg_pkg::TOT_W-1:0];
            tdg_pkg::CSR_N_TOTAL: n_total_ff <= csr_wdata[tdg_pkg::TOT_W-1:0];
            tdg_pkg::CSR_K_TOTAL: k_total_ff <= csr_wdata[tdg_pkg::TOT_W-1:0];
            tdg_pkg::CSR_LD_A:    ld_a_ff    <= csr_wdata[tdg_pkg::LD_W-1:0];
            tdg_pkg::CSR_LD_B:    ld_b_ff    <= csr_wdata[tdg_pkg::LD_W-1:0];
            tdg_pkg::CSR_LD_C:    ld_c_ff    <= csr_wdata[tdg_pkg::LD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a stage loads when its successor is empty or draining
   always_comb begin
      ready3    = !v3 || !rsp_stall;
      ready2    = !v2 || ready3;
      ready1    = !v1 || ready2;
      c1.en     = ready1;
      c1.vld_in = req_valid;
      c2.en     = ready2;
      c2.vld_in = v1;
      c3.en     = ready3;
      c3.vld_in = v2;
   end

   assign req_stall = !ready1;

   tdg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (c1),
      .m_tile  (req_m_tile),
      .n_tile  (req_n_tile),
      .k_tile  (req_k_tile),
      .op_mode (op_mode_ff),
      .m_total (m_total_ff),
      .n_total (n_total_ff),
      .k_total (k_total_ff),
      .valid   (v1),
      .stage   (s1)
   );

   tdg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctrl  (c2),
      .s1    (s1),
      .ld_a  (ld_a_ff),
      .ld_b  (ld_b_ff),
      .ld_c  (ld_c_ff),
      .valid (v2),
      .stage (s2)
   );

   tdg_back u_back (
      .clock (clock),
      .reset (reset),
      .ctrl  (c3),
      .s2    (s2),
      .valid (v3),
      .stage (s3)
   );

   assign rsp_valid      = v3;
   assign rsp_in_range   = s3.in_range;
   assign rsp_m_len      = s3.m_len;
   assign rsp_n_len      = s3.n_len;
   assign rsp_k_len      = s3.k_len;
   assign rsp_a_offset   = s3.a_offset;
   assign rsp_b_offset   = s3.b_offset;
   assign rsp_c_offset   = s3.c_offset;
   assign rsp_first_k    = s3.first_k;
   assign rsp_last_k     = s3.last_k;
   assign rsp_tile_count = s3.tile_count;

endmodule

// File: sv/tdg_front.sv
// ----------------------------------------------------------------------------
// tdg_front
// First stage: grid counts, range check, tile lengths, k flags and the
// multiplier operands for the three block origins.
// ----------------------------------------------------------------------------
module tdg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  tdg_pkg::stg_ctrl_type       ctrl,
   input  logic [tdg_pkg::IDX_W-1:0]   m_tile,
   input  logic [tdg_pkg::IDX_W-1:0]   n_tile,
   input  logic [tdg_pkg::IDX_W-1:0]   k_tile,
   input  logic [tdg_pkg::MODE_W-1:0]  op_mode,
   input  logic [tdg_pkg::TOT_W-1:0]   m_total,
   input  logic [tdg_pkg::TOT_W-1:0]   n_total,
   input  logic [tdg_pkg::TOT_W-1:0]   k_total,
   output logic                        valid,
   output tdg_pkg::s1_type             stage
);

   logic                        valid_ff;
   tdg_pkg::s1_type             stage_ff;
   tdg_pkg::s1_type             stage_in;

   logic [tdg_pkg::TOT_W-1:0]   m_rem;
   logic [tdg_pkg::TOT_W-1:0]   n_rem;
   logic [tdg_pkg::TOT_W-1:0]   k_rem;
   logic                        m_grow;
   logic                        n_grow;
   logic                        k_grow;
   logic [tdg_pkg::TOT_W-1:0]   m_last;
   logic [tdg_pkg::TOT_W-1:0]   n_last;
   logic [tdg_pkg::TOT_W-1:0]   k_last;
   logic [tdg_pkg::CNT_M_W-1:0] gm;
   logic [tdg_pkg::CNT_N_W-1:0] gn;
   logic [tdg_pkg::CNT_K_W-1:0] gk;
   logic                        ok;
   logic [tdg_pkg::SCL_W-1:0]   mo;
   logic [tdg_pkg::SCL_W-1:0]   no;
   logic [tdg_pkg::SCL_W-1:0]   ko;

   always_comb begin
      // a remainder above a quarter tile becomes a short last tile
      m_rem  = tdg_pkg::TOT_W'(m_total % tdg_pkg::TILE_M);
      n_rem  = tdg_pkg::TOT_W'(n_total % tdg_pkg::TILE_N);
      k_rem  = tdg_pkg::TOT_W'(k_total % tdg_pkg::TILE_K);
      m_grow = m_rem > tdg_pkg::TOT_W'(tdg_pkg::TILE_M / 4);
      n_grow = n_rem > tdg_pkg::TOT_W'(tdg_pkg::TILE_N / 4);
      k_grow = k_rem > tdg_pkg::TOT_W'(tdg_pkg::TILE_K / 4);
      gm = tdg_pkg::CNT_M_W'(m_total / tdg_pkg::TILE_M) + tdg_pkg::CNT_M_W'(m_grow);
      gn = tdg_pkg::CNT_N_W'(n_total / tdg_pkg::TILE_N) + tdg_pkg::CNT_N_W'(n_grow);
      gk = tdg_pkg::CNT_K_W'(k_total / tdg_pkg::TILE_K) + tdg_pkg::CNT_K_W'(k_grow);
      m_last = m_grow ? m_rem : m_rem + tdg_pkg::TOT_W'(tdg_pkg::TILE_M);
      n_last = n_grow ? n_rem : n_rem + tdg_pkg::TOT_W'(tdg_pkg::TILE_N);
      k_last = k_grow ? k_rem : k_rem + tdg_pkg::TOT_W'(tdg_pkg::TILE_K);

      ok = (tdg_pkg::DIM_W'(m_tile) < tdg_pkg::DIM_W'(gm)) &&
           (tdg_pkg::DIM_W'(n_tile) < tdg_pkg::DIM_W'(gn)) &&
           (tdg_pkg::DIM_W'(k_tile) < tdg_pkg::DIM_W'(gk));

      mo = tdg_pkg::SCL_W'(tdg_pkg::SCL_W'(m_tile) * tdg_pkg::TILE_M);
      no = tdg_pkg::SCL_W'(tdg_pkg::SCL_W'(n_tile) * tdg_pkg::TILE_N);
      ko = tdg_pkg::SCL_W'(tdg_pkg::SCL_W'(k_tile) * tdg_pkg::TILE_K);

      stage_in = '0;
      stage_in.gm = gm;
      stage_in.gn = gn;
      stage_in.gk = gk;
      // out of range: everything but the count stays zero
      if (ok) begin
         stage_in.in_range = 1'b1;
         stage_in.m_len = tdg_pkg::dim_len(tdg_pkg::DIM_W'(m_tile), tdg_pkg::DIM_W'(gm),
                                           m_last, tdg_pkg::TOT_W'(tdg_pkg::TILE_M));
         stage_in.n_len = tdg_pkg::dim_len(tdg_pkg::DIM_W'(n_tile), tdg_pkg::DIM_W'(gn),
                                           n_last, tdg_pkg::TOT_W'(tdg_pkg::TILE_N));
         stage_in.k_len = tdg_pkg::dim_len(tdg_pkg::DIM_W'(k_tile), tdg_pkg::DIM_W'(gk),
                                           k_last, tdg_pkg::TOT_W'(tdg_pkg::TILE_K));
         stage_in.first_k = (k_tile == '0);
         stage_in.last_k  = ((tdg_pkg::DIM_W'(k_tile) + tdg_pkg::DIM_W'(1))
                             == tdg_pkg::DIM_W'(gk));
         // x operand is scaled by the leading dimension, y is added
         if (op_mode[tdg_pkg::MODE_A_TRANS]) begin
            stage_in.a_x = mo;
            stage_in.a_y = ko;
         end else begin
            stage_in.a_x = ko;
            stage_in.a_y = mo;
         end
         if (op_mode[tdg_pkg::MODE_B_TRANS]) begin
            stage_in.b_x = ko;
            stage_in.b_y = no;
         end else begin
            stage_in.b_x = no;
            stage_in.b_y = ko;
         end
         stage_in.c_x = no;
         stage_in.c_y = mo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.en) begin
         valid_ff <= ctrl.vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en && ctrl.vld_in) begin
         stage_ff <= stage_in;
      end
   end

   assign valid = valid_ff;
   assign stage = stage_ff;

endmodule

// File: sv/tdg_mul.sv
// ----------------------------------------------------------------------------
// tdg_mul
// Second stage: leading-dimension products of the three origins and the
// first product of the grid counts.
// ----------------------------------------------------------------------------
module tdg_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  tdg_pkg::stg_ctrl_type     ctrl,
   input  tdg_pkg::s1_type           s1,
   input  logic [tdg_pkg::LD_W-1:0]  ld_a,
   input  logic [tdg_pkg::LD_W-1:0]  ld_b,
   input  logic [tdg_pkg::LD_W-1:0]  ld_c,
   output logic                      valid,
   output tdg_pkg::s2_type           stage
);

   logic            valid_ff;
   tdg_pkg::s2_type stage_ff;
   tdg_pkg::s2_type stage_in;

   always_comb begin
      stage_in          = '0;
      stage_in.in_range = s1.in_range;
      stage_in.m_len    = s1.m_len;
      stage_in.n_len    = s1.n_len;
      stage_in.k_len    = s1.k_len;
      stage_in.first_k  = s1.first_k;
      stage_in.last_k   = s1.last_k;
      stage_in.gk       = s1.gk;
      stage_in.gmn      = tdg_pkg::MN_W'(s1.gm) * tdg_pkg::MN_W'(s1.gn);
      stage_in.a_p      = tdg_pkg::PRD_W'(s1.a_x) * tdg_pkg::PRD_W'(ld_a);
      stage_in.b_p      = tdg_pkg::PRD_W'(s1.b_x) * tdg_pkg::PRD_W'(ld_b);
      stage_in.c_p      = tdg_pkg::PRD_W'(s1.c_x) * tdg_pkg::PRD_W'(ld_c);
      stage_in.a_y      = s1.a_y;
      stage_in.b_y      = s1.b_y;
      stage_in.c_y      = s1.c_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.en) begin
         valid_ff <= ctrl.vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en && ctrl.vld_in) begin
         stage_ff <= stage_in;
      end
   end

   assign valid = valid_ff;
   assign stage = stage_ff;

endmodule

// File: sv/tdg_back.sv
// ----------------------------------------------------------------------------
// tdg_back
// Third stage: origin sums modulo the address width and the saturated tile
// count; this register is the result port.
// ----------------------------------------------------------------------------
module tdg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tdg_pkg::stg_ctrl_type ctrl,
   input  tdg_pkg::s2_type       s2,
   output logic                  valid,
   output tdg_pkg::s3_type       stage
);

   logic                       valid_ff;
   tdg_pkg::s3_type            stage_ff;
   tdg_pkg::s3_type            stage_in;
   logic [tdg_pkg::CNTP_W-1:0] count;

   always_comb begin
      count             = tdg_pkg::CNTP_W'(s2.gmn) * tdg_pkg::CNTP_W'(s2.gk);
      stage_in          = '0;
      stage_in.in_range = s2.in_range;
      stage_in.m_len    = s2.m_len;
      stage_in.n_len    = s2.n_len;
      stage_in.k_len    = s2.k_len;
      stage_in.first_k  = s2.first_k;
      stage_in.last_k   = s2.last_k;
      // offsets wrap like address arithmetic
      stage_in.a_offset = tdg_pkg::OFS_W'(s2.a_p) + tdg_pkg::OFS_W'(s2.a_y);
      stage_in.b_offset = tdg_pkg::OFS_W'(s2.b_p) + tdg_pkg::OFS_W'(s2.b_y);
      stage_in.c_offset = tdg_pkg::OFS_W'(s2.c_p) + tdg_pkg::OFS_W'(s2.c_y);
      if (64'(count) > tdg_pkg::COUNT_MAX) begin
         stage_in.tile_count = tdg_pkg::CNT_W'(tdg_pkg::COUNT_MAX);
      end else begin
         stage_in.tile_count = tdg_pkg::CNT_W'(count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.en) begin
         valid_ff <= ctrl.vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en && ctrl.vld_in) begin
         stage_ff <= stage_in;
      end
   end

   assign valid = valid_ff;
   assign stage = stage_ff;

endmodule

// File: sv/tdg_checker.sv
// ----------------------------------------------------------------------------
// tdg_checker
// Port-level checks of the tile descriptor generator, bound to the top level.
// ----------------------------------------------------------------------------
module tdg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_in_range,
   input logic [tdg_pkg::LEN_W-1:0]      rsp_m_len,
   input logic [tdg_pkg::LEN_W-1:0]      rsp_n_len,
   input logic [tdg_pkg::LEN_W-1:0]      rsp_k_len,
   input logic [tdg_pkg::OFS_W-1:0]      rsp_a_offset,
   input logic [tdg_pkg::OFS_W-1:0]      rsp_b_offset,
   input logic [tdg_pkg::OFS_W-1:0]      rsp_c_offset,
   input logic                           rsp_first_k,
   input logic                           rsp_last_k,
   input logic [tdg_pkg::CNT_W-1:0]      rsp_tile_count
);

   // an item outside the grid carries only the count
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |->
         rsp_m_len == '0 && rsp_n_len == '0 && rsp_k_len == '0 &&
         rsp_a_offset == '0 && rsp_b_offset == '0 && rsp_c_offset == '0 &&
         !rsp_first_k && !rsp_last_k)
      else $error("out-of-range item has non-zero fields");

   // a tile inside the grid is never empty and the grid count is non-zero
   a_in_range_sizes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |->
         rsp_m_len != '0 && rsp_n_len != '0 && rsp_k_len != '0 &&
         rsp_tile_count != '0)
      else $error("in-range item with empty tile or zero count");

   // input backpressure only comes from a held result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // an accepted item reaches the result port when the result side keeps draining
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("item did not reach the result port in three cycles");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_c_offset) &&
         $stable(rsp_tile_count))
      else $error("stalled result changed");

endmodule

bind gemm_tile_descriptor_generator_top tdg_checker u_tdg_checker (.*);
